// File: src/qvr_pkg.sv
// Shared types and constants for the quaternion vector rotator.
`timescale 1ns / 1ps

package qvr_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int TOL_WIDTH  = 12;

  localparam logic [TOL_WIDTH-1:0] TOL_RESET = 12'd41;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] vec_x;
    logic signed [DATA_WIDTH-1:0] vec_y;
    logic signed [DATA_WIDTH-1:0] vec_z;
    logic signed [DATA_WIDTH-1:0] quat_w;
    logic signed [DATA_WIDTH-1:0] quat_x;
    logic signed [DATA_WIDTH-1:0] quat_y;
    logic signed [DATA_WIDTH-1:0] quat_z;
  } qvr_req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] rot_x;
    logic signed [DATA_WIDTH-1:0] rot_y;
    logic signed [DATA_WIDTH-1:0] rot_z;
    logic                         unit_ok;
    logic                         saturated;
  } qvr_rsp_t;

endpackage

// File: src/qvr_round_sat.sv
// Round-half-up and saturate one wide fixed-point sum to the output width.
`timescale 1ns / 1ps

module qvr_round_sat #(
  parameter int IN_W  = 52,
  parameter int SHIFT = 24,
  parameter int OUT_W = 16
) (
  input  logic signed [IN_W-1:0]  acc_i,
  output logic signed [OUT_W-1:0] res_o,
  output logic                    sat_o
);

  localparam int RW = IN_W - SHIFT;

  localparam logic signed [IN_W-1:0]  HALF = IN_W'(1) << (SHIFT - 1);
  localparam logic signed [OUT_W-1:0] RMAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] RMIN = {1'b1, {(OUT_W-1){1'b0}}};

  logic signed [IN_W-1:0] rounded;
  logic signed [RW-1:0]   shifted;
  logic                   fits;

  always_comb begin
    rounded = acc_i + HALF;
    shifted = rounded[IN_W-1:SHIFT];
    // All bits above the output sign bit must copy it.
    fits    = (shifted[RW-1:OUT_W-1] == {(RW-OUT_W+1){1'b0}}) ||
              (shifted[RW-1:OUT_W-1] == {(RW-OUT_W+1){1'b1}});
    sat_o   = !fits;
    if (fits) begin
      res_o = shifted[OUT_W-1:0];
    end else if (shifted[RW-1]) begin
      res_o = RMIN;
    end else begin
      res_o = RMAX;
    end
  end

endmodule

// File: src/quaternion_vector_rotator.sv
// Top level of the pipelined quaternion vector rotator.
`timescale 1ns / 1ps
//
// Rotates a 3-vector v by a quaternion q = (s, u):
//   r = 2(u.v)u + (s^2 - |u|^2)v + 2s(u x v), all Q.FRAC_BITS signed.
// Input channel: in_valid_i / in_ready_o carry one request (vector and
// quaternion) per handshake. Output channel: out_valid_o / out_ready_i carry
// the rotated vector, a unit_ok flag (|q|^2 within the tolerance of one) and
// a saturated flag (some component clipped to the format bounds).
// Configuration: cfg_we_i writes cfg_wdata_i into the norm tolerance at once;
// write it only while no request is in flight.
// Acceptance to out_valid_o passes through four register stages (pair products,
// triple products, sum, round/saturate into the output register); the accepting
// edge loads the first. One request is taken per cycle while the output is not
// stalled.
// Each stage advances when its successor is free, so bubbles collapse and a
// new request is taken while a finished result still waits at the output.
// When the receiver stalls, the pipeline fills up stage by stage and then
// in_ready_o drops; nothing is lost or repeated.
// Reset clears all valid bits and loads the default tolerance of 41.

module quaternion_vector_rotator #(
  parameter int FRAC_BITS = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [qvr_pkg::TOL_WIDTH-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  qvr_pkg::qvr_req_t              in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output qvr_pkg::qvr_rsp_t              out_rsp_o
);

  localparam int W  = qvr_pkg::DATA_WIDTH;
  localparam int TW = qvr_pkg::TOL_WIDTH;
  // Pair products and their sums.
  localparam int P  = 2 * W + 2;
  // Triple products.
  localparam int T  = P + W;
  // Component sum, with headroom for the rounding offset.
  localparam int A  = (T + 2 > 2 * FRAC_BITS + W + 2) ? T + 2 : 2 * FRAC_BITS + W + 2;
  // Norm difference and tolerance compare widths.
  localparam int NW = ((P > 2 * FRAC_BITS + 2) ? P : 2 * FRAC_BITS + 2) + 1;
  localparam int CW = ((NW > TW + FRAC_BITS) ? NW : TW + FRAC_BITS) + 1;

  localparam logic signed [NW-1:0] ONE_NORM = NW'(1) << (2 * FRAC_BITS);
  localparam logic signed [W-1:0]  RMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  RMIN = {1'b1, {(W-1){1'b0}}};

  // Stage enables: a stage advances when it is empty or its successor moves.
  logic en1, en2, en3, en4;

  logic [TW-1:0] tol_q;

  // ---------------- stage 1: pair products ----------------
  logic signed [W-1:0] vi [3];
  logic signed [W-1:0] ui [3];

  logic signed [P-1:0] dot_d, a_d, nrm_d;
  logic signed [P-1:0] cr_d [3];

  logic                s1_valid_q;
  logic signed [P-1:0] dot_q, a_q, nrm_q;
  logic signed [P-1:0] cr_q [3];
  logic signed [W-1:0] v_q [3];
  logic signed [W-1:0] u_q [3];
  logic signed [W-1:0] s_q;

  // ---------------- stage 2: triple products ----------------
  logic signed [T-1:0]  t1_d [3];
  logic signed [T-1:0]  t2_d [3];
  logic signed [T-1:0]  t3_d [3];
  logic signed [NW-1:0] nd_d;
  logic [NW-1:0]        nabs_d;

  logic                s2_valid_q;
  logic signed [T-1:0] t1_q [3];
  logic signed [T-1:0] t2_q [3];
  logic signed [T-1:0] t3_q [3];
  logic [NW-1:0]       nabs_q;

  // ---------------- stage 3: component sums ----------------
  logic signed [A-1:0] acc_d [3];
  logic                ok_d;

  logic                s3_valid_q;
  logic signed [A-1:0] acc_q [3];
  logic                ok_q;

  // ---------------- stage 4: round, saturate, output ----------------
  logic signed [W-1:0] res_d [3];
  logic                sat_d [3];

  logic              out_valid_q;
  qvr_pkg::qvr_rsp_t out_q;

  // Flow control: the stall propagates back only through full stages.
  assign en4        = !out_valid_q || out_ready_i;
  assign en3        = !s3_valid_q || en4;
  assign en2        = !s2_valid_q || en3;
  assign en1        = !s1_valid_q || en2;
  assign in_ready_o = en1;

  // Tolerance register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= qvr_pkg::TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // Stage 1 logic.
  always_comb begin
    vi[0] = in_req_i.vec_x;
    vi[1] = in_req_i.vec_y;
    vi[2] = in_req_i.vec_z;
    ui[0] = in_req_i.quat_x;
    ui[1] = in_req_i.quat_y;
    ui[2] = in_req_i.quat_z;

    dot_d = P'(ui[0]) * P'(vi[0]) + P'(ui[1]) * P'(vi[1]) + P'(ui[2]) * P'(vi[2]);
    nrm_d = P'(ui[0]) * P'(ui[0]) + P'(ui[1]) * P'(ui[1]) + P'(ui[2]) * P'(ui[2]);
    a_d   = P'(in_req_i.quat_w) * P'(in_req_i.quat_w) - nrm_d;
    nrm_d = nrm_d + P'(in_req_i.quat_w) * P'(in_req_i.quat_w);
    // Cross product u x v.
    for (int i = 0; i < 3; i++) begin
      cr_d[i] = P'(ui[(i+1)%3]) * P'(vi[(i+2)%3]) - P'(ui[(i+2)%3]) * P'(vi[(i+1)%3]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en1) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      dot_q <= dot_d;
      a_q   <= a_d;
      nrm_q <= nrm_d;
      s_q   <= in_req_i.quat_w;
      for (int i = 0; i < 3; i++) begin
        cr_q[i] <= cr_d[i];
        v_q[i]  <= vi[i];
        u_q[i]  <= ui[i];
      end
    end
  end

  // Stage 2 logic.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t1_d[i] = T'(dot_q) * T'(u_q[i]);
      t2_d[i] = T'(a_q) * T'(v_q[i]);
      t3_d[i] = T'(s_q) * T'(cr_q[i]);
    end
    nd_d   = NW'(nrm_q) - ONE_NORM;
    nabs_d = nd_d[NW-1] ? NW'(-nd_d) : NW'(nd_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en2) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && s1_valid_q) begin
      nabs_q <= nabs_d;
      for (int i = 0; i < 3; i++) begin
        t1_q[i] <= t1_d[i];
        t2_q[i] <= t2_d[i];
        t3_q[i] <= t3_d[i];
      end
    end
  end

  // Stage 3 logic: exact sum at three times the fraction bits.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_d[i] = (A'(t1_q[i]) <<< 1) + A'(t2_q[i]) + (A'(t3_q[i]) <<< 1);
    end
    ok_d = CW'(nabs_q) < (CW'(tol_q) << FRAC_BITS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en3) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && s2_valid_q) begin
      ok_q <= ok_d;
      for (int i = 0; i < 3; i++) begin
        acc_q[i] <= acc_d[i];
      end
    end
  end

  // Stage 4: round each component back to FRAC_BITS and clip.
  for (genvar g = 0; g < 3; g++) begin : g_round
    qvr_round_sat #(
      .IN_W  (A),
      .SHIFT (2 * FRAC_BITS),
      .OUT_W (W)
    ) u_round_sat (
      .acc_i (acc_q[g]),
      .res_o (res_d[g]),
      .sat_o (sat_d[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en4) begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && s3_valid_q) begin
      out_q.rot_x     <= res_d[0];
      out_q.rot_y     <= res_d[1];
      out_q.rot_z     <= res_d[2];
      out_q.unit_ok   <= ok_q;
      out_q.saturated <= sat_d[0] || sat_d[1] || sat_d[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // ---------------- assertions ----------------

  // Input backs up only when the output is held by the receiver.
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_q && !out_ready_i)
    else $error("input stalled without an output stall");

  // An accepted request lands in stage 1.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> s1_valid_q)
    else $error("accepted request lost at stage 1");

  // A sum blocked behind the output holds.
  a_stage3_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q && !en4 |=> s3_valid_q && $stable(acc_q[0]) && $stable(ok_q))
    else $error("stage 3 changed while stalled");

  // A saturated result has at least one component at a bound.
  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.saturated |->
      out_q.rot_x == RMAX || out_q.rot_x == RMIN ||
      out_q.rot_y == RMAX || out_q.rot_y == RMIN ||
      out_q.rot_z == RMAX || out_q.rot_z == RMIN)
    else $error("saturated flag without a clipped component");

endmodule
